FILE: design/tcm_pkg.sv
// Shared constants, item types and result codes of the touch calibrate and map block.
`default_nettype none

package tcm_pkg;

  // Screen geometry and calibration margin
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int EDGE_MARGIN   = 15;

  // Field widths
  localparam int RAW_W  = 10;
  localparam int KIND_W = 2;
  localparam int SX_W   = 9;
  localparam int SY_W   = 8;
  localparam int EDGE_W = 12;

  // Arithmetic widths: operand differences, constant factor, dividend and divisor magnitudes
  localparam int DIFF_W = EDGE_W + 1;
  localparam int MULT_W = 13;
  localparam int NUM_W  = 24;
  localparam int DEN_W  = EDGE_W;

  localparam int EDGE_MIN = -(2 ** (EDGE_W - 1));
  localparam int EDGE_MAX = (2 ** (EDGE_W - 1)) - 1;

  // Edge values after reset
  localparam int LEFT_RESET   = 1023;
  localparam int RIGHT_RESET  = 0;
  localparam int TOP_RESET    = 0;
  localparam int BOTTOM_RESET = 1023;

  // Fixed divisors of the margin extrapolation
  localparam int CAL_DEN_V = SCREEN_HEIGHT - 2 * EDGE_MARGIN;
  localparam int CAL_DEN_H = SCREEN_WIDTH - 2 * EDGE_MARGIN;

  // Reciprocals of the fixed divisors: (n * ceil(2^S / d)) >> S equals n / d for every
  // margin product n, since n stays below 2^15 and d below 2^12
  localparam int CAL_SHIFT   = 28;
  localparam int RECIP_W     = 28;
  localparam int CAL_RECIP_V = ((2 ** CAL_SHIFT) + CAL_DEN_V - 1) / CAL_DEN_V;
  localparam int CAL_RECIP_H = ((2 ** CAL_SHIFT) + CAL_DEN_H - 1) / CAL_DEN_H;

  localparam int CORNERS   = 4;
  localparam int STEP_W    = 3;
  localparam logic [STEP_W-1:0] CAL_LAST_STEP = STEP_W'(CORNERS);

  // Command and result kind codes
  localparam logic CMD_CONVERT = 1'b0;
  localparam logic CMD_CAPTURE = 1'b1;

  localparam logic [KIND_W-1:0] KIND_POINT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

  typedef struct packed {
    logic             cmd;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
    logic             pressure;
  } tcm_in_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SX_W-1:0]   screen_x;
    logic [SY_W-1:0]   screen_y;
    logic              touch_state;
    logic              out_of_range;
    logic              span_error;
  } tcm_out_t;

endpackage

`default_nettype wire

FILE: design/tcm_chan_if.sv
// Valid/ready channel interface carrying one item of a given payload type.
`default_nettype none

interface tcm_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/tcm_div.sv
// Serial restoring divider: unsigned quotient, one bit per cycle.
`default_nettype none

module tcm_div #(
  parameter int NUM_W = tcm_pkg::NUM_W,
  parameter int DEN_W = tcm_pkg::DEN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;

  logic [DEN_W:0]   trial;
  logic             fits;
  logic [DEN_W:0]   trial_sub;
  logic [DEN_W-1:0] rem_nxt;

  always_comb begin
    trial     = {rem_r, quo_r[NUM_W-1]};
    fits      = trial >= {1'b0, den_r};
    trial_sub = trial - {1'b0, den_r};
    rem_nxt   = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        den_r  <= den;
        rem_r  <= '0;
        quo_r  <= num;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[NUM_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start && (cnt_r == CNT_W'(1)) |=> done_r && !busy_r)
    else $error("divider did not finish after its last step");

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < den_r)
    else $error("divider remainder not below divisor");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held longer than one cycle");

endmodule

`default_nettype wire

FILE: design/touch_calibrate_and_map.sv
// Top level: touch calibration capture, edge extrapolation and raw-to-pixel mapping.
`default_nettype none

// One item is taken at a time; ready is high only while the sequencer is idle, and a
// finished result waits in an output register so the next item can enter meanwhile.
// Converting a sample runs two divisions through the one serial divider, which retires
// one quotient bit per cycle, each framed by load, start and post steps; a zero span
// skips its division. A calibration's two divisions by fixed divisors are reciprocal
// multiplications instead, so calibration does not use the serial divider.
// Divisions truncate toward zero; edges saturate to 12-bit signed; mapped pixels
// clamp to the screen and raise out_of_range; a zero span raises span_error.
module touch_calibrate_and_map (
  input  logic       clk,
  input  logic       rst_n,
  tcm_chan_if.sink   in_chan,
  tcm_chan_if.source out_chan
);

  import tcm_pkg::*;

  localparam int EXT_W  = NUM_W + 2;
  localparam int PROD_W = DIFF_W + MULT_W + 1;
  localparam int RC_W   = NUM_W + RECIP_W;

  localparam logic signed [EXT_W-1:0]  EXT_MIN    = EXT_W'(EDGE_MIN);
  localparam logic signed [EXT_W-1:0]  EXT_MAX    = EXT_W'(EDGE_MAX);
  localparam logic signed [EDGE_W-1:0] EDGE_MIN_V = EDGE_W'(EDGE_MIN);
  localparam logic signed [EDGE_W-1:0] EDGE_MAX_V = EDGE_W'(EDGE_MAX);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AVG,
    S_LOAD,
    S_START,
    S_WAIT,
    S_POST,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_V,
    OP_H,
    OP_X,
    OP_Y
  } op_t;

  state_t state_r;
  op_t    op_r;

  tcm_in_t  item_r;
  tcm_out_t res_r;
  tcm_out_t out_r;
  logic     out_valid_r;

  logic [STEP_W-1:0] cal_step_r;
  logic [RAW_W-1:0]  corner_x_r [CORNERS];
  logic [RAW_W-1:0]  corner_y_r [CORNERS];
  logic [RAW_W-1:0]  avg_t_r;
  logic [RAW_W-1:0]  avg_b_r;
  logic [RAW_W-1:0]  avg_l_r;
  logic [RAW_W-1:0]  avg_r_r;

  logic signed [EDGE_W-1:0] left_r;
  logic signed [EDGE_W-1:0] right_r;
  logic signed [EDGE_W-1:0] top_r;
  logic signed [EDGE_W-1:0] bottom_r;

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic             neg_r;
  logic             skip_r;
  logic [NUM_W-1:0] recip_quo_r;

  logic             in_accept;
  logic             out_load;
  logic             cal_op;
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;

  // Operand selection and the shared multiplier
  logic signed [DIFF_W-1:0] ld_diff;
  logic signed [DIFF_W-1:0] ld_dvs;
  logic [MULT_W-1:0]        ld_mult;
  logic signed [PROD_W-1:0] ld_prod;
  logic [PROD_W-1:0]        ld_prod_abs;
  logic [DIFF_W-1:0]        ld_dvs_abs;

  // Reciprocal path for the fixed divisors
  logic [RECIP_W-1:0] rc_mult;
  logic [RC_W-1:0]    rc_prod;

  // Post-division values
  logic [NUM_W-1:0]        quo_sel;
  logic signed [EXT_W-1:0] q_ext;
  logic signed [EXT_W-1:0] sum_a;
  logic signed [EXT_W-1:0] sum_b;
  logic [NUM_W-1:0]        cl_last;
  logic [NUM_W-1:0]        cl_val;
  logic                    cl_flag;

  logic [RAW_W:0] sum_t;
  logic [RAW_W:0] sum_b4;
  logic [RAW_W:0] sum_l;
  logic [RAW_W:0] sum_r4;

  function automatic logic signed [EDGE_W-1:0] sat_edge(input logic signed [EXT_W-1:0] v);
    logic signed [EDGE_W-1:0] res;
    if (v < EXT_MIN) begin
      res = EDGE_MIN_V;
    end else if (v > EXT_MAX) begin
      res = EDGE_MAX_V;
    end else begin
      res = v[EDGE_W-1:0];
    end
    return res;
  endfunction

  assign in_accept     = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign out_load      = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);
  assign cal_op        = (op_r == OP_V) || (op_r == OP_H);
  assign div_start     = (state_r == S_START) && !skip_r && !cal_op;

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

  // Corner averages: sums are non-negative, so halving is a shift
  always_comb begin
    sum_t  = {1'b0, corner_y_r[0]} + {1'b0, corner_y_r[3]};
    sum_b4 = {1'b0, corner_y_r[1]} + {1'b0, corner_y_r[2]};
    sum_l  = {1'b0, corner_x_r[0]} + {1'b0, corner_x_r[1]};
    sum_r4 = {1'b0, corner_x_r[2]} + {1'b0, corner_x_r[3]};
  end

  always_comb begin
    case (op_r)
      OP_V: begin
        ld_diff = $signed({{(DIFF_W-RAW_W){1'b0}}, avg_b_r} - {{(DIFF_W-RAW_W){1'b0}}, avg_t_r});
        ld_dvs  = DIFF_W'(CAL_DEN_V);
        ld_mult = MULT_W'(EDGE_MARGIN);
      end
      OP_H: begin
        ld_diff = $signed({{(DIFF_W-RAW_W){1'b0}}, avg_l_r} - {{(DIFF_W-RAW_W){1'b0}}, avg_r_r});
        ld_dvs  = DIFF_W'(CAL_DEN_H);
        ld_mult = MULT_W'(EDGE_MARGIN);
      end
      OP_X: begin
        ld_diff = $signed({left_r[EDGE_W-1], left_r})
                - $signed({{(DIFF_W-RAW_W){1'b0}}, item_r.raw_x});
        ld_dvs  = $signed({left_r[EDGE_W-1], left_r}) - $signed({right_r[EDGE_W-1], right_r});
        ld_mult = MULT_W'(SCREEN_WIDTH);
      end
      default: begin
        ld_diff = $signed({{(DIFF_W-RAW_W){1'b0}}, item_r.raw_y})
                - $signed({top_r[EDGE_W-1], top_r});
        ld_dvs  = $signed({bottom_r[EDGE_W-1], bottom_r}) - $signed({top_r[EDGE_W-1], top_r});
        ld_mult = MULT_W'(SCREEN_HEIGHT);
      end
    endcase
    ld_prod     = PROD_W'(ld_diff) * PROD_W'($signed({1'b0, ld_mult}));
    ld_prod_abs = ld_prod[PROD_W-1] ? PROD_W'(-ld_prod) : PROD_W'(ld_prod);
    ld_dvs_abs  = ld_dvs[DIFF_W-1] ? DIFF_W'(-ld_dvs) : DIFF_W'(ld_dvs);
  end

  always_comb begin
    rc_mult = (op_r == OP_V) ? RECIP_W'(CAL_RECIP_V) : RECIP_W'(CAL_RECIP_H);
    rc_prod = RC_W'(num_r) * RC_W'(rc_mult);
  end

  always_comb begin
    quo_sel = cal_op ? recip_quo_r : div_quo;
    q_ext   = neg_r ? -$signed({2'b00, quo_sel}) : $signed({2'b00, quo_sel});
    if (op_r == OP_V) begin
      sum_a = $signed({{(EXT_W-RAW_W){1'b0}}, avg_t_r}) - q_ext;
      sum_b = $signed({{(EXT_W-RAW_W){1'b0}}, avg_b_r}) + q_ext;
    end else begin
      sum_a = $signed({{(EXT_W-RAW_W){1'b0}}, avg_l_r}) + q_ext;
      sum_b = $signed({{(EXT_W-RAW_W){1'b0}}, avg_r_r}) - q_ext;
    end

    cl_last = (op_r == OP_X) ? NUM_W'(SCREEN_WIDTH - 1) : NUM_W'(SCREEN_HEIGHT - 1);
    if (neg_r && (div_quo != '0)) begin
      cl_val  = '0;
      cl_flag = 1'b1;
    end else if (div_quo > cl_last) begin
      cl_val  = cl_last;
      cl_flag = 1'b1;
    end else begin
      cl_val  = div_quo;
      cl_flag = 1'b0;
    end
  end

  tcm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_V;
      cal_step_r  <= '0;
      out_valid_r <= 1'b0;
      skip_r      <= 1'b0;
      left_r      <= EDGE_W'(LEFT_RESET);
      right_r     <= EDGE_W'(RIGHT_RESET);
      top_r       <= EDGE_W'(TOP_RESET);
      bottom_r    <= EDGE_W'(BOTTOM_RESET);
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            item_r <= in_chan.data;
            if (in_chan.data.cmd == CMD_CAPTURE) begin
              if (cal_step_r < CAL_LAST_STEP) begin
                corner_x_r[cal_step_r[1:0]] <= in_chan.data.raw_x;
                corner_y_r[cal_step_r[1:0]] <= in_chan.data.raw_y;
                cal_step_r                  <= cal_step_r + 1'b1;
                res_r   <= {KIND_STORED, SX_W'(0), SY_W'(0), in_chan.data.pressure,
                            1'b0, 1'b0};
                state_r <= S_DONE;
              end else begin
                // fifth point: sample is dropped, edges are rebuilt
                cal_step_r <= '0;
                res_r      <= {KIND_DONE, SX_W'(0), SY_W'(0), in_chan.data.pressure,
                               1'b0, 1'b0};
                state_r    <= S_AVG;
              end
            end else begin
              res_r   <= {KIND_POINT, SX_W'(0), SY_W'(0), in_chan.data.pressure, 1'b0, 1'b0};
              op_r    <= OP_X;
              state_r <= S_LOAD;
            end
          end
        end

        S_AVG: begin
          avg_t_r <= sum_t[RAW_W:1];
          avg_b_r <= sum_b4[RAW_W:1];
          avg_l_r <= sum_l[RAW_W:1];
          avg_r_r <= sum_r4[RAW_W:1];
          op_r    <= OP_V;
          state_r <= S_LOAD;
        end

        S_LOAD: begin
          num_r   <= ld_prod_abs[NUM_W-1:0];
          den_r   <= ld_dvs_abs[DEN_W-1:0];
          neg_r   <= ld_prod[PROD_W-1] ^ ld_dvs[DIFF_W-1];
          skip_r  <= (ld_dvs == '0);
          state_r <= S_START;
        end

        S_START: begin
          // fixed divisors finish here through the reciprocal
          recip_quo_r <= rc_prod[RC_W-1:CAL_SHIFT];
          state_r     <= (skip_r || cal_op) ? S_POST : S_WAIT;
        end

        S_WAIT: begin
          if (div_done) begin
            state_r <= S_POST;
          end
        end

        S_POST: begin
          case (op_r)
            OP_V: begin
              top_r    <= sat_edge(sum_a);
              bottom_r <= sat_edge(sum_b);
              op_r     <= OP_H;
              state_r  <= S_LOAD;
            end
            OP_H: begin
              left_r  <= sat_edge(sum_a);
              right_r <= sat_edge(sum_b);
              state_r <= S_DONE;
            end
            OP_X: begin
              res_r   <= {res_r.kind,
                          skip_r ? SX_W'(0) : cl_val[SX_W-1:0],
                          res_r.screen_y,
                          res_r.touch_state,
                          res_r.out_of_range | (!skip_r && cl_flag),
                          res_r.span_error | skip_r};
              op_r    <= OP_Y;
              state_r <= S_LOAD;
            end
            default: begin
              res_r   <= {res_r.kind,
                          res_r.screen_x,
                          skip_r ? SY_W'(0) : cl_val[SY_W-1:0],
                          res_r.touch_state,
                          res_r.out_of_range | (!skip_r && cl_flag),
                          res_r.span_error | skip_r};
              state_r <= S_DONE;
            end
          endcase
        end

        S_DONE: begin
          // hold until the output register is free
          if (out_load) begin
            out_r   <= res_r;
            state_r <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_chan.data.cmd == CMD_CAPTURE) && (cal_step_r < CAL_LAST_STEP)
    |=> cal_step_r == $past(cal_step_r) + 1'b1)
    else $error("calibration step did not advance on a corner capture");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    cal_step_r <= CAL_LAST_STEP)
    else $error("calibration step beyond the fifth point");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load
    |=> out_valid_r && (out_r == $past(res_r)) && (state_r == S_IDLE))
    else $error("finished result not moved to the output register");

  a_cal_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.kind != KIND_POINT)
    |-> (out_r.screen_x == '0) && (out_r.screen_y == '0)
        && !out_r.out_of_range && !out_r.span_error)
    else $error("calibration result carries mapping fields");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT) && div_done |=> state_r == S_POST)
    else $error("division result not taken");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Testbench for touch_calibrate_and_map: directed table plus random calibration runs, self-checked.
module tb_top;
  import tcm_pkg::*;

  localparam int RAND_ITEMS     = 700;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int RAW_MAX        = 2 ** RAW_W - 1;

  typedef struct {
    tcm_in_t  item;
    bit       typed;
    tcm_out_t want;
  } table_row_t;

  typedef struct {
    bit       typed;
    tcm_out_t want;
  } table_check_t;

  logic clk;
  logic rst_n;

  tcm_chan_if #(.T(tcm_in_t))  in_if ();
  tcm_chan_if #(.T(tcm_out_t)) out_if ();

  touch_calibrate_and_map dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Mirror of the block state
  logic [STEP_W-1:0] cal_idx = '0;
  logic [RAW_W-1:0]  corner_xs [CORNERS];
  logic [RAW_W-1:0]  corner_ys [CORNERS];
  int left_e   = LEFT_RESET;
  int right_e  = RIGHT_RESET;
  int top_e    = TOP_RESET;
  int bottom_e = BOTTOM_RESET;

  tcm_out_t     pending_results [$];
  table_check_t table_checks [$];
  table_row_t   directed_rows [$];

  int failures       = 0;
  int idle_cycles    = 0;
  int accepted_items = 0;
  int burst_left     = 0;
  int ready_run      = 0;
  int ready_hold     = 0;
  int n_point        = 0;
  int n_clamped      = 0;
  int n_span         = 0;
  int n_stored       = 0;
  int n_done         = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int clip_edge(longint v);
    if (v < EDGE_MIN) return EDGE_MIN;
    if (v > EDGE_MAX) return EDGE_MAX;
    return int'(v);
  endfunction

  // Advance the mirrored state by one item and return the result it should produce
  function automatic tcm_out_t touch_response(tcm_in_t it);
    tcm_out_t res;
    longint   t, b, l, r, fv, fh, dx, dy, v;
    bit       clamped;
    res = '0;
    res.touch_state = it.pressure;
    clamped = 1'b0;
    if (it.cmd == CMD_CAPTURE) begin
      if (cal_idx < CAL_LAST_STEP) begin
        corner_xs[cal_idx[1:0]] = it.raw_x;
        corner_ys[cal_idx[1:0]] = it.raw_y;
        cal_idx = cal_idx + 1'b1;
        res.kind = KIND_STORED;
      end else begin
        // corners: top-left, bottom-left, bottom-right, top-right
        t  = (longint'(corner_ys[0]) + longint'(corner_ys[3])) / 2;
        b  = (longint'(corner_ys[1]) + longint'(corner_ys[2])) / 2;
        l  = (longint'(corner_xs[0]) + longint'(corner_xs[1])) / 2;
        r  = (longint'(corner_xs[2]) + longint'(corner_xs[3])) / 2;
        fv = (EDGE_MARGIN * (b - t)) / CAL_DEN_V;
        fh = (EDGE_MARGIN * (l - r)) / CAL_DEN_H;
        top_e    = clip_edge(t - fv);
        bottom_e = clip_edge(b + fv);
        left_e   = clip_edge(l + fh);
        right_e  = clip_edge(r - fh);
        cal_idx  = '0;
        res.kind = KIND_DONE;
      end
    end else begin
      res.kind = KIND_POINT;
      dx = longint'(left_e) - right_e;
      dy = longint'(bottom_e) - top_e;
      if (dx == 0) begin
        res.span_error = 1'b1;
      end else begin
        v = (SCREEN_WIDTH * (longint'(left_e) - longint'(it.raw_x))) / dx;
        if (v < 0) begin
          v = 0;
          clamped = 1'b1;
        end else if (v > SCREEN_WIDTH - 1) begin
          v = SCREEN_WIDTH - 1;
          clamped = 1'b1;
        end
        res.screen_x = v[SX_W-1:0];
      end
      if (dy == 0) begin
        res.span_error = 1'b1;
      end else begin
        v = (SCREEN_HEIGHT * (longint'(it.raw_y) - longint'(top_e))) / dy;
        if (v < 0) begin
          v = 0;
          clamped = 1'b1;
        end else if (v > SCREEN_HEIGHT - 1) begin
          v = SCREEN_HEIGHT - 1;
          clamped = 1'b1;
        end
        res.screen_y = v[SY_W-1:0];
      end
      res.out_of_range = clamped;
    end
    return res;
  endfunction

  function automatic void log_failure(string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  function automatic void add_row(logic cmd, int x, int y, logic p,
                                  bit typed = 1'b0, tcm_out_t want = '0);
    table_row_t row;
    row.item  = {cmd, RAW_W'(x), RAW_W'(y), p};
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [RAW_W-1:0] near_raw(int base, int spread);
    int v;
    v = int'($urandom_range(0, 2 * spread)) + base - spread;
    if (v < 0) v = 0;
    if (v > RAW_MAX) v = RAW_MAX;
    return v[RAW_W-1:0];
  endfunction

  // Drive one item at the falling edge and hold it until the block takes it
  task automatic send_item(tcm_in_t it, bit typed, tcm_out_t want);
    int           gap;
    table_check_t chk;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    chk.typed = typed;
    chk.want  = want;
    table_checks.push_back(chk);
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    burst_left--;
    accepted_items++;
    @(negedge clk);
  endtask

  // Receiver: runs of ready broken by stalls, with an occasional long clean stretch
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (ready_run > 0) begin
      out_if.ready <= 1'b1;
      ready_run--;
    end else if (ready_hold > 0) begin
      out_if.ready <= 1'b0;
      ready_hold--;
    end else begin
      ready_run  = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 24);
      ready_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 4);
      out_if.ready <= 1'b0;
    end
  end

  // Predict on input acceptance, then check any result taken at the same edge
  always @(posedge clk) begin
    tcm_out_t     want;
    tcm_out_t     got;
    table_check_t chk;
    bit           moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_if.valid && in_if.ready) begin
        moved = 1'b1;
        chk  = table_checks.pop_front();
        want = touch_response(in_if.data);
        pending_results.push_back(chk.typed ? chk.want : want);
      end
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        got = out_if.data;
        if (pending_results.size() == 0) begin
          log_failure($sformatf("unexpected result: kind %0d x %0d y %0d flags %b%b%b",
                                got.kind, got.screen_x, got.screen_y, got.touch_state,
                                got.out_of_range, got.span_error));
        end else begin
          want = pending_results.pop_front();
          // fields: kind/x/y then touch, clamp, span flags
          if (got.kind !== want.kind || got.screen_x !== want.screen_x ||
              got.screen_y !== want.screen_y || got.touch_state !== want.touch_state ||
              got.out_of_range !== want.out_of_range || got.span_error !== want.span_error)
            log_failure($sformatf("mismatch: exp %0d/%0d/%0d/%b%b%b got %0d/%0d/%0d/%b%b%b",
                                  want.kind, want.screen_x, want.screen_y, want.touch_state,
                                  want.out_of_range, want.span_error,
                                  got.kind, got.screen_x, got.screen_y, got.touch_state,
                                  got.out_of_range, got.span_error));
          if (want.kind == KIND_POINT) begin
            n_point++;
            n_clamped += want.out_of_range;
            n_span    += want.span_error;
          end else if (want.kind == KIND_STORED) begin
            n_stored++;
          end else begin
            n_done++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    @(posedge rst_n);
    while (idle_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("watchdog: %0d cycles with no item moving", WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    tcm_in_t it;
    int      xl, xr, yt, yb, spread, flat, mode;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;

    // Reset edges: a raw x of 0 and a raw y at the maximum clamp
    add_row(CMD_CONVERT, 0, 0, 1'b1, 1'b1, {KIND_POINT, 9'd319, 8'd0, 1'b1, 1'b1, 1'b0});
    add_row(CMD_CONVERT, RAW_MAX, RAW_MAX, 1'b0, 1'b1,
            {KIND_POINT, 9'd0, 8'd239, 1'b0, 1'b1, 1'b0});
    // Regular calibration, centre point ignored
    add_row(CMD_CAPTURE, 100, 80, 1'b1, 1'b1, {KIND_STORED, 9'd0, 8'd0, 1'b1, 1'b0, 1'b0});
    add_row(CMD_CAPTURE, 100, 950, 1'b0, 1'b1, {KIND_STORED, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0});
    add_row(CMD_CAPTURE, 920, 950, 1'b1, 1'b1, {KIND_STORED, 9'd0, 8'd0, 1'b1, 1'b0, 1'b0});
    add_row(CMD_CAPTURE, 920, 80, 1'b0, 1'b1, {KIND_STORED, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0});
    add_row(CMD_CAPTURE, 512, 512, 1'b1, 1'b1, {KIND_DONE, 9'd0, 8'd0, 1'b1, 1'b0, 1'b0});
    add_row(CMD_CONVERT, 0, RAW_MAX, 1'b1);
    add_row(CMD_CONVERT, 512, 500, 1'b0);
    // Flat x span, with a conversion in the middle of the sequence
    add_row(CMD_CAPTURE, 500, 100, 1'b1);
    add_row(CMD_CAPTURE, 500, 900, 1'b1);
    add_row(CMD_CONVERT, RAW_MAX, 0, 1'b0);
    add_row(CMD_CAPTURE, 500, 900, 1'b0);
    add_row(CMD_CAPTURE, 500, 100, 1'b1);
    add_row(CMD_CAPTURE, 0, 0, 1'b0, 1'b1, {KIND_DONE, 9'd0, 8'd0, 1'b0, 1'b0, 1'b0});
    add_row(CMD_CONVERT, 700, 500, 1'b1);
    // Flat y span
    add_row(CMD_CAPTURE, 50, 300, 1'b0);
    add_row(CMD_CAPTURE, 50, 300, 1'b1);
    add_row(CMD_CAPTURE, 980, 300, 1'b0);
    add_row(CMD_CAPTURE, 980, 300, 1'b1);
    add_row(CMD_CAPTURE, RAW_MAX, RAW_MAX, 1'b1);
    add_row(CMD_CONVERT, 300, 300, 1'b1);
    // Both spans flat: nothing mapped
    add_row(CMD_CAPTURE, 600, 600, 1'b1);
    add_row(CMD_CAPTURE, 600, 600, 1'b0);
    add_row(CMD_CAPTURE, 600, 600, 1'b1);
    add_row(CMD_CAPTURE, 600, 600, 1'b0);
    add_row(CMD_CAPTURE, 600, 600, 1'b1);
    add_row(CMD_CONVERT, 0, RAW_MAX, 1'b0, 1'b1, {KIND_POINT, 9'd0, 8'd0, 1'b0, 1'b0, 1'b1});

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    while (accepted_items < directed_rows.size() + RAND_ITEMS) begin
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
        // Well-formed calibration around random edges, then conversions against it
        xl = $urandom_range(0, RAW_MAX);
        xr = $urandom_range(0, RAW_MAX);
        yt = $urandom_range(0, RAW_MAX);
        yb = $urandom_range(0, RAW_MAX);
        spread = $urandom_range(0, 24);
        flat = $urandom_range(0, 9);
        if (flat == 0) begin
          xr = xl;
          spread = 0;
        end else if (flat == 1) begin
          yb = yt;
          spread = 0;
        end
        for (int k = 0; k < CORNERS; k++) begin
          it.cmd      = CMD_CAPTURE;
          it.raw_x    = near_raw((k < 2) ? xl : xr, spread);
          it.raw_y    = near_raw((k == 0 || k == 3) ? yt : yb, spread);
          it.pressure = 1'($urandom_range(0, 1));
          send_item(it, 1'b0, '0);
        end
        it.cmd      = CMD_CAPTURE;
        it.raw_x    = RAW_W'($urandom_range(0, RAW_MAX));
        it.raw_y    = RAW_W'($urandom_range(0, RAW_MAX));
        it.pressure = 1'($urandom_range(0, 1));
        send_item(it, 1'b0, '0);
        repeat ($urandom_range(2, 12)) begin
          it.cmd      = CMD_CONVERT;
          it.raw_x    = RAW_W'($urandom_range(0, RAW_MAX));
          it.raw_y    = RAW_W'($urandom_range(0, RAW_MAX));
          it.pressure = 1'($urandom_range(0, 1));
          send_item(it, 1'b0, '0);
        end
      end else begin
        // Noise: random commands that break up the capture sequence
        repeat ($urandom_range(1, 6)) begin
          it.cmd      = 1'($urandom_range(0, 1));
          it.raw_x    = RAW_W'($urandom_range(0, RAW_MAX));
          it.raw_y    = RAW_W'($urandom_range(0, RAW_MAX));
          it.pressure = 1'($urandom_range(0, 1));
          send_item(it, 1'b0, '0);
        end
      end
    end

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d items: %0d conversions (%0d clamped, %0d with a flat span),",
             accepted_items, n_point, n_clamped, n_span);
    $display("%0d corner captures and %0d completed calibrations; %0d failures.",
             n_stored, n_done, failures);
    if (failures == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
